### rtl/date_pair_day_difference_unit_assert.svh
// Assertion macros for the date pair day difference unit.
// Relies on clk and arst_n being visible in the module that uses them.
`ifndef DATE_PAIR_DAY_DIFFERENCE_UNIT_ASSERT_SVH
`define DATE_PAIR_DAY_DIFFERENCE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on the rising clock edge
`define DPD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpd: same-cycle check failed");

// next-cycle implication
`define DPD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpd: next-cycle check failed");

`else

`define DPD_ASSERT_IMP(name, ante, cons)
`define DPD_ASSERT_NXT(name, ante, cons)

`endif

`endif

### rtl/dpd_pkg.sv
// Shared widths, reciprocal constants, month tables and lane types for the
// date pair day difference unit. No dependencies.
package dpd_pkg;

	localparam int DATE_W = 27;
	localparam int DAY_W  = 8;   // up to 134 for packed values above 99999999
	localparam int MON_W  = 7;   // up to 99
	localparam int YEAR_W = 14;  // up to 9999
	localparam int QUO_W  = 14;  // packed value / 10000, up to 13421
	localparam int DNUM_W = 22;  // day number, below 3660000
	localparam int DIFF_W = 23;
	localparam int KEY_W  = YEAR_W + MON_W + DAY_W;
	localparam int MLEN_W = 5;
	localparam int MSTART_W = 9;
	localparam int LEAPS_W = 12;
	localparam int HUND_W = 7;   // year / 100 and friends, up to 103

	// x / 1000000 = (x * DAY_RECIP) >> DAY_SHIFT, exact for x < 2^27
	localparam int DAY_RECIP_W = 28;
	localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 28'd140737489;
	localparam int DAY_SHIFT = 47;

	// x / 10000 = (x * QUO_RECIP) >> QUO_SHIFT, exact for x < 2^27
	localparam int QUO_RECIP_W = 27;
	localparam logic [QUO_RECIP_W-1:0] QUO_RECIP = 27'd109951163;
	localparam int QUO_SHIFT = 40;

	// y / 100 = (y * HUND_RECIP) >> HUND_SHIFT, exact for y < 2^14
	localparam logic [YEAR_W-1:0] HUND_RECIP = 14'd10486;
	localparam int HUND_SHIFT = 20;

	localparam int MON_SCALE     = 100;
	localparam int YEAR_SCALE    = 10000;
	localparam int CENTURY       = 100;
	localparam int DAYS_PER_YEAR = 365;
	localparam int PAD4   = 3;
	localparam int PAD100 = 99;
	localparam int PAD400 = 399;

	localparam logic [MON_W-1:0] MON_JAN = 7'd1;
	localparam logic [MON_W-1:0] MON_FEB = 7'd2;
	localparam logic [MON_W-1:0] MON_DEC = 7'd12;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} dpd_stage_en_t;

	typedef struct packed {
		logic [DNUM_W-1:0] day_num;
		logic [KEY_W-1:0]  order_key;  // {year, month, day}
		logic              ok;
	} dpd_lane_res_t;

	// Days in month, February without the leap day; 0 for months that do not exist
	function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] m);
		logic [MLEN_W-1:0] r;
		case (m)
			7'd1:    r = 5'd31;
			7'd2:    r = 5'd28;
			7'd3:    r = 5'd31;
			7'd4:    r = 5'd30;
			7'd5:    r = 5'd31;
			7'd6:    r = 5'd30;
			7'd7:    r = 5'd31;
			7'd8:    r = 5'd31;
			7'd9:    r = 5'd30;
			7'd10:   r = 5'd31;
			7'd11:   r = 5'd30;
			7'd12:   r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Days before the first of month m; saturates at a full year past December
	function automatic logic [MSTART_W-1:0] month_start(input logic [MON_W-1:0] m);
		logic [MSTART_W-1:0] r;
		case (m)
			7'd0:    r = 9'd0;
			7'd1:    r = 9'd0;
			7'd2:    r = 9'd31;
			7'd3:    r = 9'd59;
			7'd4:    r = 9'd90;
			7'd5:    r = 9'd120;
			7'd6:    r = 9'd151;
			7'd7:    r = 9'd181;
			7'd8:    r = 9'd212;
			7'd9:    r = 9'd243;
			7'd10:   r = 9'd273;
			7'd11:   r = 9'd304;
			7'd12:   r = 9'd334;
			default: r = 9'd365;
		endcase
		return r;
	endfunction

endpackage

### rtl/dpd_lane.sv
// One date lane: unpacks a DDMMYYYY word and turns it into a day number,
// validity flag and ordering key over five register stages. Uses dpd_pkg.
module dpd_lane (
	input  logic                   clk,
	input  dpd_pkg::dpd_stage_en_t en,
	input  logic [dpd_pkg::DATE_W-1:0] date,
	output dpd_pkg::dpd_lane_res_t res
);
	import dpd_pkg::*;

	localparam int DPROD_W = DATE_W + DAY_RECIP_W;
	localparam int QPROD_W = DATE_W + QUO_RECIP_W;
	localparam int QSCL_W  = 2 * QUO_W;
	localparam int DSCL_W  = DAY_W + MON_W;
	localparam int HPROD_W = 2 * YEAR_W;

	// stage 1: both constant divisions by reciprocal multiply
	logic [DPROD_W-1:0] day_prod;
	logic [QPROD_W-1:0] quo_prod;
	logic [DAY_W-1:0]   day_s1;
	logic [QUO_W-1:0]   quo_s1;
	logic [YEAR_W-1:0]  low_s1;

	assign day_prod = DPROD_W'(date) * DPROD_W'(DAY_RECIP);
	assign quo_prod = QPROD_W'(date) * QPROD_W'(QUO_RECIP);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			day_s1 <= day_prod[DAY_SHIFT +: DAY_W];
			quo_s1 <= quo_prod[QUO_SHIFT +: QUO_W];
			low_s1 <= date[YEAR_W-1:0];
		end
	end

	// stage 2: remainders; the results are small, so modular arithmetic is enough
	logic [QSCL_W-1:0] quo_scaled;
	logic [DSCL_W-1:0] day_scaled;
	logic [YEAR_W-1:0] year_s2;
	logic [MON_W-1:0]  month_s2;
	logic [DAY_W-1:0]  day_s2;

	assign quo_scaled = QSCL_W'(quo_s1) * QSCL_W'(YEAR_SCALE);
	assign day_scaled = DSCL_W'(day_s1) * DSCL_W'(MON_SCALE);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			year_s2  <= low_s1 - quo_scaled[YEAR_W-1:0];
			month_s2 <= quo_s1[MON_W-1:0] - day_scaled[MON_W-1:0];
			day_s2   <= day_s1;
		end
	end

	// stage 3: century quotients and the year term
	logic [HPROD_W-1:0] h_prod;
	logic [HPROD_W-1:0] c100_prod;
	logic [HPROD_W-1:0] c400_prod;
	logic [HUND_W-1:0]  hund_s3;
	logic [HUND_W-1:0]  c100_s3;
	logic [HUND_W-1:0]  c400_s3;
	logic [DNUM_W-1:0]  y365_s3;
	logic [YEAR_W-1:0]  year_s3;
	logic [MON_W-1:0]   month_s3;
	logic [DAY_W-1:0]   day_s3;

	assign h_prod    = HPROD_W'(year_s2) * HPROD_W'(HUND_RECIP);
	assign c100_prod = HPROD_W'(year_s2 + YEAR_W'(PAD100)) * HPROD_W'(HUND_RECIP);
	assign c400_prod = HPROD_W'(year_s2 + YEAR_W'(PAD400)) * HPROD_W'(HUND_RECIP);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			hund_s3  <= h_prod[HUND_SHIFT +: HUND_W];
			c100_s3  <= c100_prod[HUND_SHIFT +: HUND_W];
			c400_s3  <= c400_prod[HUND_SHIFT +: HUND_W];
			y365_s3  <= DNUM_W'(year_s2) * DNUM_W'(DAYS_PER_YEAR);
			year_s3  <= year_s2;
			month_s3 <= month_s2;
			day_s3   <= day_s2;
		end
	end

	// stage 4: leap rule, leap count of earlier years, month table, validity
	logic [YEAR_W-1:0]  hund_scaled;
	logic [HUND_W-1:0]  rem100;
	logic               leap;
	logic [YEAR_W-1:0]  year_p4;
	logic [LEAPS_W-1:0] leaps;
	logic [MLEN_W-1:0]  lim;
	logic               ok;

	assign hund_scaled = YEAR_W'(hund_s3) * YEAR_W'(CENTURY);
	assign rem100  = year_s3[HUND_W-1:0] - hund_scaled[HUND_W-1:0];
	// divisible by 400 means divisible by 100 with a quotient divisible by 4
	assign leap    = ((year_s3[1:0] == 2'd0) && (rem100 != '0)) ||
	                 ((rem100 == '0) && (hund_s3[1:0] == 2'd0));
	assign year_p4 = year_s3 + YEAR_W'(PAD4);
	assign leaps   = year_p4[YEAR_W-1:2] - LEAPS_W'(c100_s3) + LEAPS_W'(c400_s3[HUND_W-1:2]);
	assign lim     = month_len(month_s3) + MLEN_W'((month_s3 == MON_FEB) && leap);
	assign ok      = (month_s3 >= MON_JAN) && (month_s3 <= MON_DEC) &&
	                 (day_s3 != '0) && (day_s3 <= DAY_W'(lim));

	logic [DNUM_W-1:0]   y365_s4;
	logic [LEAPS_W-1:0]  leaps_s4;
	logic [MSTART_W-1:0] mstart_s4;
	logic                leap_add_s4;
	logic [DAY_W-1:0]    day_s4;
	logic [KEY_W-1:0]    key_s4;
	logic                ok_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y365_s4     <= y365_s3;
			leaps_s4    <= leaps;
			mstart_s4   <= month_start(month_s3);
			leap_add_s4 <= leap && (month_s3 > MON_FEB);
			day_s4      <= day_s3;
			key_s4      <= {year_s3, month_s3, day_s3};
			ok_s4       <= ok;
		end
	end

	// stage 5: sum the day number
	dpd_lane_res_t res_s5;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			res_s5.day_num   <= y365_s4 + DNUM_W'(day_s4) + DNUM_W'(mstart_s4) +
			                    DNUM_W'(leaps_s4) + DNUM_W'(leap_add_s4);
			res_s5.order_key <= key_s4;
			res_s5.ok        <= ok_s4;
		end
	end

	assign res = res_s5;

endmodule

### rtl/dpd_merge.sv
// Merge stage: subtracts the two lane day numbers, orders the dates and
// holds the output word. Uses dpd_pkg.
module dpd_merge (
	input  logic                   clk,
	input  logic                   en,
	input  dpd_pkg::dpd_lane_res_t first_res,
	input  dpd_pkg::dpd_lane_res_t second_res,
	output logic signed [dpd_pkg::DIFF_W-1:0] day_difference,
	output logic                   first_valid,
	output logic                   second_valid,
	output logic                   second_not_earlier
);
	import dpd_pkg::*;

	logic [DIFF_W-1:0] diff;

	assign diff = DIFF_W'(second_res.day_num) - DIFF_W'(first_res.day_num);

	always_ff @(posedge clk) begin
		if (en) begin
			day_difference     <= diff;
			first_valid        <= first_res.ok;
			second_valid       <= second_res.ok;
			// fields are packed most significant first, so one compare orders them
			second_not_earlier <= second_res.order_key >= first_res.order_key;
		end
	end

endmodule

### rtl/date_pair_day_difference_unit.sv
// Top level of the date pair day difference unit: two conversion lanes,
// the merge stage and the stage valid chain. Uses dpd_pkg, dpd_lane, dpd_merge.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, first_date, second_date | into block
//   out     | out_valid, out_ready, day_difference,       | out of block
//           | first_valid, second_valid, second_not_earlier |
//
// One word per cycle sustained while out_ready stays high; an accepted word passes
// through the five lane stages and then the merge/output register to the output.
// Each stage holds only while the stage after it is full and held, so
// bubbles close up and input is taken while a result waits at the output.
// in_ready follows out_ready combinationally through that chain.
// Reset clears only the stage valid bits; there is no clearing pass.
`include "date_pair_day_difference_unit_assert.svh"

module date_pair_day_difference_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [dpd_pkg::DATE_W-1:0] first_date,
	input  logic [dpd_pkg::DATE_W-1:0] second_date,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [dpd_pkg::DIFF_W-1:0] day_difference,
	output logic                   first_valid,
	output logic                   second_valid,
	output logic                   second_not_earlier
);
	import dpd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv6;
	dpd_stage_en_t en;
	dpd_lane_res_t first_res;
	dpd_lane_res_t second_res;

	// a stage may load when it is empty or its content moves on
	assign adv6  = !v_s6 || out_ready;
	assign en.s5 = !v_s5 || adv6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign in_ready  = en.s1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (adv6)  v_s6 <= v_s5;
		end
	end

	dpd_lane u_first_lane (
		.clk  (clk),
		.en   (en),
		.date (first_date),
		.res  (first_res)
	);

	dpd_lane u_second_lane (
		.clk  (clk),
		.en   (en),
		.date (second_date),
		.res  (second_res)
	);

	dpd_merge u_merge (
		.clk                (clk),
		.en                 (adv6),
		.first_res          (first_res),
		.second_res         (second_res),
		.day_difference     (day_difference),
		.first_valid        (first_valid),
		.second_valid       (second_valid),
		.second_not_earlier (second_not_earlier)
	);

	// input backs up only when every stage is full and the output is held
	`DPD_ASSERT_IMP(a_full_stall, !in_ready, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !out_ready)
	// a finished lane result reaches the output register when there is room
	`DPD_ASSERT_NXT(a_lane_to_out, v_s5 && adv6, v_s6)
	// for two real dates the day count and the field order agree
	`DPD_ASSERT_IMP(a_order_match, out_valid && first_valid && second_valid, second_not_earlier == !day_difference[DIFF_W-1])

endmodule
